// ===== hdl/sis_pkg.sv =====
// sis_pkg: sizes, command and status codes, cell control types and the
// thermometer count helper for the sorted interval set
// no dependencies
package sis_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = IDX_W + 1;
  localparam int unsigned ROT_W    = IDX_W - 1;
  localparam int unsigned VAL_W    = 62;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned ST_W     = 2;

  localparam logic [CMD_W-1:0] CMD_ADD       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INTERSECT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  // broadcast to every cell; each cell matches the indexes against its own
  typedef struct packed {
    logic             wr_a;
    logic [IDX_W-1:0] idx_a;
    logic             wr_b;
    logic [IDX_W-1:0] idx_b;
    logic             shl;
    logic [IDX_W-1:0] shl_from;
    logic             shr2;
    logic [IDX_W-1:0] shr_from;
    logic             rot;
  } cell_op_t;

  typedef struct packed {
    logic le_a;
    logic lt_a;
    logic le_b;
    logic lt_b;
  } cell_flags_t;

  // number of ones in a prefix thermometer, from the position of its last one
  function automatic logic [CNT_W-1:0] therm_count(input logic [CAPACITY-1:0] t);
    logic [CAPACITY:0] te;
    logic [CNT_W-1:0]  c;
    te = {1'b0, t};
    c  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (te[i] && !te[i+1]) c = c | CNT_W'(i + 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/sis_if.sv =====
// sis_in_if and sis_out_if: valid/ready channels for commands and results
// depends on sis_pkg
interface sis_in_if;
  logic                         valid;
  logic                         ready;
  logic [sis_pkg::CMD_W-1:0]    command;
  logic [sis_pkg::VAL_W-1:0]    range_start;
  logic [sis_pkg::VAL_W-1:0]    range_end;
  logic [sis_pkg::IDX_W-1:0]    read_index;

  modport source (output valid, command, range_start, range_end, read_index,
                  input ready);
  modport sink (input valid, command, range_start, range_end, read_index,
                output ready);
endinterface

interface sis_out_if;
  logic                         valid;
  logic                         ready;
  logic [sis_pkg::ST_W-1:0]     status;
  logic [sis_pkg::VAL_W-1:0]    boundary_value;
  logic [sis_pkg::CNT_W-1:0]    boundary_count;
  logic [sis_pkg::VAL_W-1:0]    covered_total;

  modport source (output valid, status, boundary_value, boundary_count, covered_total,
                  input ready);
  modport sink (input valid, status, boundary_value, boundary_count, covered_total,
                output ready);
endinterface

// ===== hdl/sorted_interval_set.sv =====
// sorted_interval_set: set of disjoint half-open ranges kept as a sorted
// boundary list in a row of sis_cell slots; depends on sis_pkg, sis_if, sis_cell
// add, remove and intersect go through evaluate, plan and apply, and remove and
// intersect then shift out each erased boundary; clear answers after evaluate;
// read rotates the ring to sum ranges; one command at a time until its result is taken
// reset clears the boundary count and control state; slot contents are not reset
module sorted_interval_set (
  input  logic      clk_i,
  input  logic      rst_ni,
  sis_in_if.sink    in_i,
  sis_out_if.source out_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EVAL  = 7'b0000010,
    S_PLAN  = 7'b0000100,
    S_APPLY = 7'b0001000,
    S_ERASE = 7'b0010000,
    S_ROT   = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_e;

  localparam int unsigned CW = sis_pkg::CNT_W;
  localparam int unsigned IW = sis_pkg::IDX_W;
  localparam logic [CW:0] CAP_X = (CW + 1)'(sis_pkg::CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(sis_pkg::CAPACITY);

  state_e                        state_q;
  logic [sis_pkg::CMD_W-1:0]     cmd_q;
  logic [sis_pkg::VAL_W-1:0]     a_q, b_q;
  logic [IW-1:0]                 idx_q;
  logic [CW-1:0]                 count_q;
  logic [sis_pkg::ST_W-1:0]      status_q;
  logic [sis_pkg::VAL_W-1:0]     value_q, total_q;
  logic [sis_pkg::ROT_W-1:0]     rot_q;
  logic [sis_pkg::CAPACITY-1:0]  le_a_q, lt_a_q, le_b_q, lt_b_q;
  logic [sis_pkg::CAPACITY-1:0]  le_a_w, lt_a_w, le_b_w, lt_b_w;
  sis_pkg::cell_op_t             op_q, cur_op, pl_op;
  logic [CW-1:0]                 n1_q, efrom_q, elen_q;
  logic [CW-1:0]                 pl_n1, pl_efrom, pl_elen;
  logic                          pl_full;

  logic [CW-1:0] c_le_a, c_lt_a, c_le_b, c_lt_b;
  logic [CW-1:0] p1, p2, s_pos, e_pos, q_pos, r_pos;
  logic          in1, in2, empty_rng, grow_full;

  logic [sis_pkg::VAL_W-1:0] cell_val [sis_pkg::CAPACITY];
  sis_pkg::cell_flags_t      cell_flg [sis_pkg::CAPACITY];

  // chain of slots
  for (genvar g = 0; g < sis_pkg::CAPACITY; g++) begin : g_cell
    logic [sis_pkg::VAL_W-1:0] up1, up2, dn2;
    if (g < sis_pkg::CAPACITY - 1) begin : g_up1
      assign up1 = cell_val[g+1];
    end else begin : g_up1_end
      assign up1 = cell_val[g];
    end
    if (g >= 2) begin : g_dn2
      assign dn2 = cell_val[g-2];
    end else begin : g_dn2_end
      assign dn2 = cell_val[g];
    end
    assign up2 = cell_val[(g + 2) % sis_pkg::CAPACITY];

    sis_cell u_cell (
      .clk_i   (clk_i),
      .index_i (IW'(g)),
      .count_i (count_q),
      .op_i    (cur_op),
      .a_i     (a_q),
      .b_i     (b_q),
      .up1_i   (up1),
      .up2_i   (up2),
      .dn2_i   (dn2),
      .value_o (cell_val[g]),
      .flags_o (cell_flg[g])
    );

    assign le_a_w[g] = cell_flg[g].le_a;
    assign lt_a_w[g] = cell_flg[g].lt_a;
    assign le_b_w[g] = cell_flg[g].le_b;
    assign lt_b_w[g] = cell_flg[g].lt_b;
  end

  always_comb begin
    cur_op = '0;
    if (state_q == S_APPLY) begin
      cur_op = op_q;
    end else if (state_q == S_ERASE) begin
      cur_op.shl      = 1'b1;
      cur_op.shl_from = efrom_q[IW-1:0];
    end else if (state_q == S_ROT) begin
      cur_op.rot = 1'b1;
    end
  end

  // plan the edit from the four registered thermometers
  assign c_le_a    = sis_pkg::therm_count(le_a_q);
  assign c_lt_a    = sis_pkg::therm_count(lt_a_q);
  assign c_le_b    = sis_pkg::therm_count(le_b_q);
  assign c_lt_b    = sis_pkg::therm_count(lt_b_q);
  assign empty_rng = b_q <= a_q;
  assign grow_full = ({1'b0, count_q} + (CW + 1)'(2)) > CAP_X;

  assign p1    = c_lt_a;
  assign p2    = c_le_b;
  assign in1   = p1[0];
  assign in2   = p2[0];
  assign s_pos = p1 + CW'(in1);
  assign e_pos = p2 - CW'(in2);
  assign q_pos = c_lt_b;
  assign r_pos = c_le_a;

  always_comb begin
    pl_op    = '0;
    pl_n1    = count_q;
    pl_efrom = '0;
    pl_elen  = '0;
    pl_full  = 1'b0;
    unique case (cmd_q)
      sis_pkg::CMD_ADD: begin
        if (!empty_rng) begin
          if (count_q != '0 && c_lt_a < count_q) begin
            // starts at or below the last end: only the last end can move
            if (c_lt_b == count_q) begin
              pl_op.wr_b  = 1'b1;
              pl_op.idx_b = IW'(count_q - CW'(1));
            end
          end else if (grow_full) begin
            pl_full = 1'b1;
          end else begin
            pl_op.wr_a  = 1'b1;
            pl_op.idx_a = count_q[IW-1:0];
            pl_op.wr_b  = 1'b1;
            pl_op.idx_b = IW'(count_q + CW'(1));
            pl_n1       = count_q + CW'(2);
          end
        end
      end
      sis_pkg::CMD_REMOVE: begin
        if (!empty_rng && count_q != '0 && c_lt_b != '0 && c_le_a != count_q) begin
          if (c_lt_a == '0 && c_le_b == count_q) begin
            pl_n1 = '0;
          end else if (in1 && in2 && p1 >= p2) begin
            // hole inside one range: split it
            if (grow_full) begin
              pl_full = 1'b1;
            end else begin
              pl_op.shr2     = 1'b1;
              pl_op.shr_from = p1[IW-1:0];
              pl_op.wr_a     = 1'b1;
              pl_op.idx_a    = p1[IW-1:0];
              pl_op.wr_b     = 1'b1;
              pl_op.idx_b    = IW'(p1 + CW'(1));
              pl_n1          = count_q + CW'(2);
            end
          end else begin
            if (in1 && p1 < count_q) begin
              pl_op.wr_a  = 1'b1;
              pl_op.idx_a = p1[IW-1:0];
            end
            if (in2) begin
              pl_op.wr_b  = 1'b1;
              pl_op.idx_b = IW'(p2 - CW'(1));
            end
            if (s_pos < e_pos) begin
              pl_efrom = s_pos;
              pl_elen  = e_pos - s_pos;
            end
          end
        end
      end
      sis_pkg::CMD_INTERSECT: begin
        if (count_q != '0) begin
          if (empty_rng || c_lt_b == '0 || c_le_a == count_q) begin
            pl_n1 = '0;
          end else if (!(c_lt_a == '0 && c_le_b == count_q)) begin
            // cut the tail, close the open range at b, then trim the head at a
            if (q_pos[0] && q_pos < CAP_C) begin
              pl_op.wr_b  = 1'b1;
              pl_op.idx_b = q_pos[IW-1:0];
              pl_n1       = q_pos + CW'(1);
            end else begin
              pl_n1 = q_pos;
            end
            if (r_pos[0]) begin
              pl_op.wr_a  = 1'b1;
              pl_op.idx_a = IW'(r_pos - CW'(1));
            end
            pl_efrom = '0;
            pl_elen  = {r_pos[CW-1:1], 1'b0};
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rot_q    <= '0;
      elen_q   <= '0;
      n1_q     <= '0;
      efrom_q  <= '0;
      op_q     <= '0;
      cmd_q    <= '0;
      a_q      <= '0;
      b_q      <= '0;
      idx_q    <= '0;
      status_q <= sis_pkg::ST_OK;
      value_q  <= '0;
      total_q  <= '0;
      le_a_q   <= '0;
      lt_a_q   <= '0;
      le_b_q   <= '0;
      lt_b_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            cmd_q    <= in_i.command;
            a_q      <= in_i.range_start;
            b_q      <= in_i.range_end;
            idx_q    <= in_i.read_index;
            status_q <= sis_pkg::ST_OK;
            value_q  <= '0;
            total_q  <= '0;
            rot_q    <= '0;
            state_q  <= S_EVAL;
          end
        end
        S_EVAL: begin
          le_a_q <= le_a_w;
          lt_a_q <= lt_a_w;
          le_b_q <= le_b_w;
          lt_b_q <= lt_b_w;
          unique case (cmd_q)
            sis_pkg::CMD_ADD, sis_pkg::CMD_REMOVE, sis_pkg::CMD_INTERSECT: begin
              state_q <= S_PLAN;
            end
            sis_pkg::CMD_CLEAR: begin
              count_q <= '0;
              state_q <= S_RESP;
            end
            sis_pkg::CMD_READ: begin
              if ({1'b0, idx_q} >= count_q) status_q <= sis_pkg::ST_RANGE;
              state_q <= S_ROT;
            end
            default: begin
              state_q <= S_RESP;
            end
          endcase
        end
        S_PLAN: begin
          op_q    <= pl_op;
          n1_q    <= pl_n1;
          efrom_q <= pl_efrom;
          elen_q  <= pl_elen;
          if (pl_full) status_q <= sis_pkg::ST_FULL;
          state_q <= S_APPLY;
        end
        S_APPLY: begin
          count_q <= n1_q;
          state_q <= (elen_q != '0) ? S_ERASE : S_RESP;
        end
        S_ERASE: begin
          count_q <= count_q - CW'(1);
          elen_q  <= elen_q - CW'(1);
          if (elen_q == CW'(1)) state_q <= S_RESP;
        end
        S_ROT: begin
          // slots 0 and 1 hold pair rot_q; the ring comes home after the last step
          if ({1'b0, rot_q, 1'b1} < count_q) begin
            total_q <= total_q + (cell_val[1] - cell_val[0]);
          end
          if (idx_q[IW-1:1] == rot_q && {1'b0, idx_q} < count_q) begin
            value_q <= idx_q[0] ? cell_val[1] : cell_val[0];
          end
          rot_q <= rot_q + sis_pkg::ROT_W'(1);
          if (rot_q == '1) state_q <= S_RESP;
        end
        S_RESP: begin
          if (out_o.ready) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready           = state_q == S_IDLE;
  assign out_o.valid          = state_q == S_RESP;
  assign out_o.status         = status_q;
  assign out_o.boundary_value = value_q;
  assign out_o.boundary_count = count_q;
  assign out_o.covered_total  = total_q;

  a_count_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !count_q[0])
    else $error("boundary count odd between commands");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_C)
    else $error("boundary count beyond capacity");

  a_erase_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ERASE |-> elen_q != '0 && count_q != '0)
    else $error("erase with nothing left to remove");

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("accepting while a result waits");

endmodule

// ===== hdl/sis_cell.sv =====
// sis_cell: one boundary slot of the chain; compares against the range ends
// and loads, shifts or rotates under the broadcast op; depends on sis_pkg
module sis_cell (
  input  logic                      clk_i,
  input  logic [sis_pkg::IDX_W-1:0] index_i,
  input  logic [sis_pkg::CNT_W-1:0] count_i,
  input  sis_pkg::cell_op_t         op_i,
  input  logic [sis_pkg::VAL_W-1:0] a_i,
  input  logic [sis_pkg::VAL_W-1:0] b_i,
  input  logic [sis_pkg::VAL_W-1:0] up1_i,
  input  logic [sis_pkg::VAL_W-1:0] up2_i,
  input  logic [sis_pkg::VAL_W-1:0] dn2_i,
  output logic [sis_pkg::VAL_W-1:0] value_o,
  output sis_pkg::cell_flags_t      flags_o
);

  logic [sis_pkg::VAL_W-1:0] value_q, value_d;
  logic                      live;
  logic [sis_pkg::CNT_W-1:0] idx_ext, shr_lim;

  assign idx_ext = {1'b0, index_i};
  assign shr_lim = {1'b0, op_i.shr_from} + sis_pkg::CNT_W'(2);
  assign live    = idx_ext < count_i;

  assign flags_o.lt_a = live && (value_q < a_i);
  assign flags_o.le_a = live && (value_q <= a_i);
  assign flags_o.lt_b = live && (value_q < b_i);
  assign flags_o.le_b = live && (value_q <= b_i);

  always_comb begin
    value_d = value_q;
    priority if (op_i.wr_a && op_i.idx_a == index_i) begin
      value_d = a_i;
    end else if (op_i.wr_b && op_i.idx_b == index_i) begin
      value_d = b_i;
    end else if (op_i.rot) begin
      value_d = up2_i;
    end else if (op_i.shl && index_i >= op_i.shl_from) begin
      value_d = up1_i;
    end else if (op_i.shr2 && idx_ext >= shr_lim) begin
      value_d = dn2_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// ===== sim/sis_tb_if.sv =====
// testbench-side view of the command and result channels
// depends on sis_pkg; the sis_if interfaces are instantiated directly in tb
package sis_tb_pkg;

  typedef struct packed {
    logic [sis_pkg::CMD_W-1:0] command;
    logic [sis_pkg::VAL_W-1:0] range_start;
    logic [sis_pkg::VAL_W-1:0] range_end;
    logic [sis_pkg::IDX_W-1:0] read_index;
  } cmd_item_t;

  typedef struct packed {
    logic [sis_pkg::ST_W-1:0]  status;
    logic [sis_pkg::VAL_W-1:0] boundary_value;
    logic [sis_pkg::CNT_W-1:0] boundary_count;
    logic [sis_pkg::VAL_W-1:0] covered_total;
  } reply_item_t;
endpackage

// ===== sim/tb.sv =====
// tb: directed table then random commands for sorted_interval_set, every reply
// checked against a behavioural range-set model; depends on sis_pkg, sis_if, sis_tb_pkg
module tb;

  localparam int unsigned VW  = sis_pkg::VAL_W;
  localparam int unsigned IW  = sis_pkg::IDX_W;
  localparam int unsigned CW  = sis_pkg::CMD_W;
  localparam int unsigned NW  = sis_pkg::CNT_W;
  localparam int unsigned CAP = sis_pkg::CAPACITY;

  // codes with no operation behind them
  localparam logic [CW-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CW-1:0] CMD_SPARE_HI = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #1 clk_i = ~clk_i;

  sis_in_if  cmd_ch ();
  sis_out_if rsp_ch ();

  sorted_interval_set u_top (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(cmd_ch), .out_o(rsp_ch));

  localparam logic [VW-1:0] VMAX = {VW{1'b1}};

  // model state
  logic [VW-1:0] bnd [CAP];
  int            nb;

  sis_tb_pkg::reply_item_t pending_replies [$];
  int          errors = 0;
  bit          no_idle = 1'b0;
  bit          hold_off = 1'b0;

  // number of boundaries <= v, minus one
  function automatic int pos_at_or_below(logic [VW-1:0] v);
    int lo, hi, mid;
    lo = 0;
    hi = nb;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (v >= bnd[mid]) lo = mid + 1;
      else hi = mid;
    end
    return lo - 1;
  endfunction

  function automatic void drop_span(int s, int e);
    if (s < 0) s = 0;
    if (e > nb) e = nb;
    if (s >= e) return;
    for (int i = 0; i < nb - e; i++) bnd[s+i] = bnd[e+i];
    nb -= e - s;
  endfunction

  function automatic logic [sis_pkg::ST_W-1:0] set_add(logic [VW-1:0] a, logic [VW-1:0] b);
    if (b <= a) return sis_pkg::ST_OK;
    if (nb > 0 && a <= bnd[nb-1]) begin
      if (b > bnd[nb-1]) bnd[nb-1] = b;
      return sis_pkg::ST_OK;
    end
    if (nb + 2 > CAP) return sis_pkg::ST_FULL;
    bnd[nb] = a;
    bnd[nb+1] = b;
    nb += 2;
    return sis_pkg::ST_OK;
  endfunction

  function automatic logic [sis_pkg::ST_W-1:0] set_remove(logic [VW-1:0] a, logic [VW-1:0] b);
    int p1, p2, at;
    bit in1, in2;
    if (b <= a || nb == 0) return sis_pkg::ST_OK;
    if (b <= bnd[0] || a >= bnd[nb-1]) return sis_pkg::ST_OK;
    if (a <= bnd[0] && b >= bnd[nb-1]) begin
      nb = 0;
      return sis_pkg::ST_OK;
    end
    p1 = pos_at_or_below(a);
    p2 = pos_at_or_below(b);
    if (p1 >= 0 && bnd[p1] == a) p1--;
    in1 = p1 >= 0 && (p1 % 2) == 0;
    in2 = p2 >= 0 && (p2 % 2) == 0;
    if (in1 && in2 && p1 + 1 > p2) begin
      if (nb + 2 > CAP) return sis_pkg::ST_FULL;
      at = p1 + 1;
      if (at > nb) at = nb;
      for (int i = nb - 1; i >= at; i--) bnd[i+2] = bnd[i];
      bnd[at] = a;
      bnd[at+1] = b;
      nb += 2;
    end else begin
      if (in1 && p1 + 1 < nb) bnd[p1+1] = a;
      if (in2 && p2 < nb) bnd[p2] = b;
      drop_span(p1 + 1 + (in1 ? 1 : 0), p2 + 1 - (in2 ? 1 : 0));
    end
    return sis_pkg::ST_OK;
  endfunction

  function automatic void set_intersect(logic [VW-1:0] a, logic [VW-1:0] b);
    int p1, p2;
    if (nb == 0) return;
    if (b <= a || b <= bnd[0] || a >= bnd[nb-1]) begin
      nb = 0;
      return;
    end
    if (a <= bnd[0] && b >= bnd[nb-1]) return;
    p2 = pos_at_or_below(b);
    if (p2 >= 0 && bnd[p2] == b) p2--;
    drop_span(p2 + 1, nb);
    if (p2 >= 0 && (p2 % 2) == 0 && nb < CAP) begin
      bnd[nb] = b;
      nb++;
    end
    p1 = pos_at_or_below(a);
    if (p1 >= 0 && (p1 % 2) == 0) begin
      bnd[p1] = a;
      p1--;
    end
    if (p1 >= 0) drop_span(0, p1 + 1);
  endfunction

  function automatic sis_tb_pkg::reply_item_t predict_reply(sis_tb_pkg::cmd_item_t c);
    sis_tb_pkg::reply_item_t r;
    r = '0;
    case (c.command)
      sis_pkg::CMD_ADD:       r.status = set_add(c.range_start, c.range_end);
      sis_pkg::CMD_REMOVE:    r.status = set_remove(c.range_start, c.range_end);
      sis_pkg::CMD_INTERSECT: set_intersect(c.range_start, c.range_end);
      sis_pkg::CMD_CLEAR:     nb = 0;
      sis_pkg::CMD_READ: begin
        if (c.read_index < nb) r.boundary_value = bnd[c.read_index];
        else r.status = sis_pkg::ST_RANGE;
        for (int j = 0; j + 1 < nb; j += 2)
          r.covered_total += bnd[j+1] - bnd[j];
      end
      default: ;
    endcase
    r.boundary_count = NW'(nb);
    return r;
  endfunction

  // directed table; a typed-in reply is checked against the block as well
  typedef struct {
    sis_tb_pkg::cmd_item_t   c;
    bit                      typed;
    sis_tb_pkg::reply_item_t r;
  } dir_row_t;

  dir_row_t dir_rows [$];
  sis_tb_pkg::reply_item_t typed_replies [$];
  bit          typed_flags [$];

  function automatic sis_tb_pkg::cmd_item_t mk(logic [CW-1:0] op, logic [VW-1:0] a,
                                               logic [VW-1:0] b, logic [IW-1:0] ix);
    sis_tb_pkg::cmd_item_t c;
    c.command = op;
    c.range_start = a;
    c.range_end = b;
    c.read_index = ix;
    return c;
  endfunction

  function automatic void row(sis_tb_pkg::cmd_item_t c);
    dir_row_t d;
    d.c = c;
    d.typed = 1'b0;
    d.r = '0;
    dir_rows.push_back(d);
  endfunction

  function automatic void row_known(sis_tb_pkg::cmd_item_t c, logic [sis_pkg::ST_W-1:0] st,
                                    logic [VW-1:0] v, logic [NW-1:0] n, logic [VW-1:0] t);
    dir_row_t d;
    d.c = c;
    d.typed = 1'b1;
    d.r.status = st;
    d.r.boundary_value = v;
    d.r.boundary_count = n;
    d.r.covered_total = t;
    dir_rows.push_back(d);
  endfunction

  function automatic void build_table();
    row_known(mk(sis_pkg::CMD_READ, 0, 0, 0), sis_pkg::ST_RANGE, 0, 0, 0);   // read after reset
    row_known(mk(sis_pkg::CMD_ADD, 5, 5, 0), sis_pkg::ST_OK, 0, 0, 0);       // empty range
    row_known(mk(sis_pkg::CMD_ADD, 0, 1, 0), sis_pkg::ST_OK, 0, 2, 0);       // single value
    row(mk(sis_pkg::CMD_ADD, 0, 10, 0));                                     // below last end
    row(mk(sis_pkg::CMD_ADD, 20, 30, 0));
    row(mk(sis_pkg::CMD_ADD, 40, VMAX, 0));                                  // top of range
    row(mk(sis_pkg::CMD_READ, 0, 0, 5));
    row(mk(sis_pkg::CMD_REMOVE, 24, 26, 0));                                 // split
    row(mk(sis_pkg::CMD_REMOVE, 5, 45, 0));
    row(mk(sis_pkg::CMD_REMOVE, 9, 3, 0));                                   // empty remove
    row(mk(sis_pkg::CMD_READ, 0, 0, 3));
    row(mk(sis_pkg::CMD_INTERSECT, 2, 60, 0));
    row(mk(sis_pkg::CMD_READ, 0, 0, 63));                                    // index beyond
    row(mk(sis_pkg::CMD_REMOVE, 0, VMAX, 0));                                // remove all
    row_known(mk(sis_pkg::CMD_READ, 0, 0, 0), sis_pkg::ST_RANGE, 0, 0, 0);
    row(mk(sis_pkg::CMD_ADD, 100, 200, 0));
    row(mk(sis_pkg::CMD_INTERSECT, 150, 150, 0));                            // empty intersect
    row(mk(sis_pkg::CMD_ADD, 7, 9, 0));
    row(mk(sis_pkg::CMD_INTERSECT, 0, VMAX, 0));
    row(mk(sis_pkg::CMD_READ, VMAX, VMAX, 1));
    row(mk(CMD_SPARE_LO, VMAX, 0, 63));                                      // unknown commands
    row(mk(CMD_SPARE_HI, 1, 2, 0));
    row_known(mk(sis_pkg::CMD_CLEAR, VMAX, VMAX, 63), sis_pkg::ST_OK, 0, 0, 0);
    // fill to capacity then overflow
    for (int k = 0; k < CAP / 2; k++)
      row(mk(sis_pkg::CMD_ADD, VW'(10 * k + 1), VW'(10 * k + 5), 0));
    row_known(mk(sis_pkg::CMD_ADD, 1000, 1001, 0), sis_pkg::ST_FULL, 0, NW'(CAP), 0);
    row(mk(sis_pkg::CMD_REMOVE, 2, 3, 0));                                   // split when full
    row(mk(sis_pkg::CMD_READ, 0, 0, 63));
    row(mk(sis_pkg::CMD_CLEAR, 0, 0, 0));
  endfunction

  // mostly well-formed ranges over a narrow window so that ranges meet and overlap
  function automatic sis_tb_pkg::cmd_item_t rand_cmd();
    sis_tb_pkg::cmd_item_t c;
    logic [VW-1:0] base, a, b;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      c.range_start = VW'({$urandom, $urandom});
      c.range_end = VW'({$urandom, $urandom});
    end else begin
      base = (sel < 15) ? VMAX - VW'(4000) : '0;
      a = base + VW'($urandom_range(0, 3000));
      b = a + VW'($urandom_range(0, 120)) - ((sel < 20) ? VW'(30) : '0);
      c.range_start = a;
      c.range_end = b;
    end
    sel = $urandom_range(0, 99);
    if (sel < 42) c.command = sis_pkg::CMD_ADD;
    else if (sel < 64) c.command = sis_pkg::CMD_REMOVE;
    else if (sel < 72) c.command = sis_pkg::CMD_INTERSECT;
    else if (sel < 75) c.command = sis_pkg::CMD_CLEAR;
    else if (sel < 97) c.command = sis_pkg::CMD_READ;
    else c.command = CW'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    c.read_index = IW'($urandom);
    return c;
  endfunction

  // valid stays up after a transfer only until the next call drives it again
  task automatic send_cmd(sis_tb_pkg::cmd_item_t c);
    while (!no_idle && $urandom_range(0, 99) < 13) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.command <= c.command;
    cmd_ch.range_start <= c.range_start;
    cmd_ch.range_end <= c.range_end;
    cmd_ch.read_index <= c.read_index;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
  endtask

  // predictions are taken at the transfer so they queue in order
  always @(posedge clk_i) begin
    if (rst_ni && cmd_ch.valid && cmd_ch.ready)
      pending_replies.push_back(predict_reply({cmd_ch.command, cmd_ch.range_start,
                                               cmd_ch.range_end, cmd_ch.read_index}));
  end

  task automatic report(string what, logic [VW-1:0] exp_v, logic [VW-1:0] act_v);
    errors++;
    if (errors <= 10)
      $display("mismatch %s: expected %0h got %0h", what, exp_v, act_v);
  endtask

  task automatic check_reply(string tag, sis_tb_pkg::reply_item_t e);
    if (rsp_ch.status !== e.status)
      report({tag, "status"}, VW'(e.status), VW'(rsp_ch.status));
    if (rsp_ch.boundary_value !== e.boundary_value)
      report({tag, "boundary_value"}, e.boundary_value, rsp_ch.boundary_value);
    if (rsp_ch.boundary_count !== e.boundary_count)
      report({tag, "boundary_count"}, VW'(e.boundary_count), VW'(rsp_ch.boundary_count));
    if (rsp_ch.covered_total !== e.covered_total)
      report({tag, "covered_total"}, e.covered_total, rsp_ch.covered_total);
  endtask

  always @(posedge clk_i) begin
    sis_tb_pkg::reply_item_t exp_r, typed_r;
    bit has_typed;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_replies.size() == 0) begin
        report("unexpected reply", '0, VW'(rsp_ch.status));
      end else begin
        exp_r = pending_replies.pop_front();
        check_reply("", exp_r);
        if (typed_flags.size() > 0) begin
          has_typed = typed_flags.pop_front();
          typed_r = typed_replies.pop_front();
          if (has_typed) check_reply("table entry ", typed_r);
        end
      end
    end
  end

  // result side: random stall, a quiet stretch, and one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= !hold_off && (no_idle || $urandom_range(0, 99) >= 13);
  end

  initial begin
    int cnt;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = sis_pkg::CMD_CLEAR;
    cmd_ch.range_start = '0;
    cmd_ch.range_end = '0;
    cmd_ch.read_index = '0;
    for (int i = 0; i < CAP; i++) bnd[i] = '0;
    nb = 0;
    build_table();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      typed_flags.push_back(dir_rows[i].typed);
      typed_replies.push_back(dir_rows[i].r);
      send_cmd(dir_rows[i].c);
    end
    for (int n = 0; n < 890; n++) begin
      no_idle = (n >= 300 && n < 450);
      if (n == 600) begin
        hold_off = 1'b1;
        fork
          begin
            repeat (400) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      send_cmd(rand_cmd());
    end
    cmd_ch.valid <= 1'b0;
    @(posedge clk_i);
    cnt = 0;
    while (pending_replies.size() != 0 && cnt < 200000) begin
      @(posedge clk_i);
      cnt++;
    end
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending_replies.size() == 0)
      $display("sorted_interval_set verification clean");
    else
      $display("sorted_interval_set verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("sorted_interval_set verification failed");
    $finish;
  end
endmodule
